FILE: design/aidba_pkg.sv
// Shared types, constants and helpers for the association ID bitmap allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package aidba_pkg;

	// Bitmap geometry
	localparam int BITMAP_WORDS = 64;
	localparam int WORD_BITS    = 32;
	localparam int BIT_IDX_W    = $clog2(WORD_BITS);
	localparam int WORD_IDX_W   = $clog2(BITMAP_WORDS);
	localparam int ID_W         = 11;
	localparam int ID_SPAN      = BITMAP_WORDS * WORD_BITS;

	// Highest identifier that may be handed out
	localparam logic [ID_W-1:0] ID_LIMIT = ID_W'(2006);

	// Request kinds
	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// Response status codes
	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_POOL_FULL = 2'd1;
	localparam logic [1:0] ST_RELEASED  = 2'd2;
	localparam logic [1:0] ST_IGNORED   = 2'd3;

	typedef struct packed {
		logic            req_type;
		logic [ID_W-1:0] release_id;
	} aidba_req_t;

	typedef struct packed {
		logic [ID_W-1:0] granted_id;
		logic [1:0]      status;
	} aidba_rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // capture incoming request
		logic read;   // pick word, issue bitmap read
		logic write;  // resolve, write back, load response
	} aidba_cmd_t;

	// Index of the lowest clear bit in a word (0 if none)
	function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
		logic [BIT_IDX_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = BIT_IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

FILE: design/aidba_ctrl.sv
// Request sequencer for the ID allocator: accept, read, write-back.
// Depends on aidba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aidba_ctrl
	import aidba_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output      logic       req_ready,
	output      logic       rsp_valid,
	input  wire logic       rsp_ready,
	output      aidba_cmd_t cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_READ  = 2'd1;
	localparam logic [1:0] S_WRITE = 2'd2;

	logic [1:0] state_q;
	logic       rsp_valid_q;
	logic       out_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	// Commands
	always_comb begin
		cmd.load  = req_valid && req_ready;
		cmd.read  = (state_q == S_READ);
		cmd.write = (state_q == S_WRITE) && out_free;
	end

	// State and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.write) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/aidba_dp.sv
// Datapath of the ID allocator: bitmap memory, per-word valid and full flags,
// word search and bit update, response register. Depends on aidba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aidba_dp
	import aidba_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire aidba_cmd_t cmd,
	input  wire aidba_req_t req,
	output      aidba_rsp_t rsp
);

	logic [WORD_BITS-1:0]  mem [BITMAP_WORDS];
	logic [BITMAP_WORDS-1:0] valid_q;
	logic [BITMAP_WORDS-1:0] full_q;

	aidba_req_t            req_q;
	logic [WORD_IDX_W-1:0] word_idx_q;
	logic                  none_q;
	logic [WORD_BITS-1:0]  rd_data_q;
	logic                  rd_valid_q;
	aidba_rsp_t            rsp_q;

	logic [WORD_IDX_W-1:0] free_word;
	logic [WORD_IDX_W-1:0] rd_addr;
	logic [WORD_BITS-1:0]  raw_word;
	logic [WORD_BITS-1:0]  id0_mask;
	logic [WORD_BITS-1:0]  eff_word;
	logic [BIT_IDX_W-1:0]  alloc_bit;
	logic [BIT_IDX_W-1:0]  rel_bit;
	logic [ID_W-1:0]       alloc_id;
	logic                  rel_bad;
	logic                  wr_en;
	logic [WORD_BITS-1:0]  wr_data;
	aidba_rsp_t            rsp_next;

	assign rsp = rsp_q;

	// Lowest word that still has a free identifier
	always_comb begin
		free_word = '0;
		for (int i = BITMAP_WORDS - 1; i >= 0; i--) begin
			if (!full_q[i]) free_word = WORD_IDX_W'(i);
		end
	end

	assign rd_addr = (req_q.req_type == REQ_ALLOC) ? free_word
		: req_q.release_id[BIT_IDX_W +: WORD_IDX_W];

	// Request capture and bitmap read
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.read) begin
			word_idx_q <= rd_addr;
			none_q     <= (req_q.req_type == REQ_ALLOC) && (&full_q);
			rd_data_q  <= mem[rd_addr];
			rd_valid_q <= valid_q[rd_addr];
		end
		if (wr_en) mem[word_idx_q] <= wr_data;
		if (cmd.write) rsp_q <= rsp_next;
	end

	// Identifier 0 is treated as permanently taken
	assign raw_word  = rd_valid_q ? rd_data_q : '0;
	assign id0_mask  = (word_idx_q == '0) ? WORD_BITS'(1) : '0;
	assign eff_word  = raw_word | id0_mask;
	assign alloc_bit = first_zero(eff_word);
	assign alloc_id  = ID_W'({word_idx_q, alloc_bit});
	assign rel_bit   = req_q.release_id[BIT_IDX_W-1:0];
	assign rel_bad   = (req_q.release_id == '0)
		|| ({1'b0, req_q.release_id} >= (ID_W + 1)'(ID_SPAN));

	// Resolve request and build write-back
	always_comb begin
		wr_en    = 1'b0;
		wr_data  = raw_word;
		rsp_next.granted_id = req_q.release_id;
		rsp_next.status     = ST_RELEASED;
		if (req_q.req_type == REQ_ALLOC) begin
			if (none_q || (alloc_id > ID_LIMIT)) begin
				rsp_next.granted_id = '0;
				rsp_next.status     = ST_POOL_FULL;
			end else begin
				wr_en   = cmd.write;
				wr_data = raw_word | (WORD_BITS'(1) << alloc_bit);
				rsp_next.granted_id = alloc_id;
				rsp_next.status     = ST_ALLOCATED;
			end
		end else if (rel_bad) begin
			rsp_next.status = ST_IGNORED;
		end else begin
			wr_en   = cmd.write;
			wr_data = raw_word & ~(WORD_BITS'(1) << rel_bit);
		end
	end

	// Per-word valid and full flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			full_q  <= '0;
		end else if (wr_en) begin
			valid_q[word_idx_q] <= 1'b1;
			full_q[word_idx_q]  <= &(wr_data | id0_mask);
		end
	end

endmodule

`default_nettype wire

FILE: design/association_id_bitmap_allocator_core.sv
// Top level of the association ID bitmap allocator.
// Depends on aidba_pkg, aidba_ctrl, aidba_dp.
//
// Channel   Dir  Handshake              Payload
// req       in   req_valid / req_ready  aidba_req_t {req_type, release_id}
// rsp       out  rsp_valid / rsp_ready  aidba_rsp_t {granted_id, status}
//
// Each request steps through accept, bitmap word read and write-back with the
// response loaded into the output register; the single-port bitmap memory
// and one request in flight set this sequence.
// Reset clears the per-word valid and full flags; no clearing pass is needed.
// A waiting response does not block acceptance of the next request; a
// stalled output holds the write-back stage until the response is taken.
`timescale 1ns / 1ps
`default_nettype none

module association_id_bitmap_allocator_core
	import aidba_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output      logic       req_ready,
	input  wire aidba_req_t req,
	output      logic       rsp_valid,
	input  wire logic       rsp_ready,
	output      aidba_rsp_t rsp
);

	aidba_cmd_t cmd;

	aidba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	aidba_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

FILE: design/aidba_checker.sv
// Port-level checks for the association ID bitmap allocator, bound to the top.
// Depends on aidba_pkg and association_id_bitmap_allocator_core.
`timescale 1ns / 1ps
`default_nettype none

module aidba_checker
	import aidba_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire aidba_req_t req,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire aidba_rsp_t rsp
);

	// Waiting request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed while waiting");

	// Stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// One request in flight: no accept right after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another in flight");

	// Granted identifiers are never 0 and never above the limit
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_ALLOCATED)
		|-> (rsp.granted_id != '0) && (rsp.granted_id <= ID_LIMIT))
		else $error("granted identifier out of range");

	// Pool full reports identifier 0
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_POOL_FULL) |-> (rsp.granted_id == '0))
		else $error("pool full with nonzero identifier");

endmodule

bind association_id_bitmap_allocator_core aidba_checker u_aidba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire
